FILE: rtl/systematic_resampler_top_assert.svh
// Assertion macros for the systematic resampler RTL.
// Expects signals clk and arst_n in the including module's scope.
`ifndef SYSTEMATIC_RESAMPLER_TOP_ASSERT_SVH
`define SYSTEMATIC_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/srs_pkg.sv
// Shared types and constants for the systematic resampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srs_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int WEIGHT_BITS_DEF   = 16;
	localparam int WEIGHT_FIELD_W    = 16;
	localparam int INDEX_FIELD_W     = 6;

	typedef struct packed {
		logic [WEIGHT_FIELD_W-1:0] weight;
		logic                      last_weight;
	} sample_t;

	typedef struct packed {
		logic [INDEX_FIELD_W-1:0] chosen_index;
		logic                     last_draw;
	} draw_t;

	// operations of the shared adder
	typedef enum logic [1:0] {
		OP_NONE,
		OP_TGT_INIT,
		OP_TGT_STEP,
		OP_CUM_ADD
	} acc_op_t;

	typedef struct packed {
		acc_op_t op;
		logic    mul_en;
		logic    clr;
	} acc_ctl_t;

endpackage

FILE: rtl/srs_wmem.sv
// Weight store: one write port, one registered read port.
// Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_wmem import srs_pkg::*; #(
	parameter int DEPTH = MAX_PARTICLES_DEF,
	parameter int WB    = WEIGHT_BITS_DEF,
	parameter int AW    = $clog2(MAX_PARTICLES_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [WB-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WB-1:0] rdata
);

	logic [WB-1:0] mem_q [DEPTH];
	logic [WB-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/srs_accum.sv
// Shared scaled arithmetic: multiplier stage, one adder, one comparator.
// Holds the scaled cumulative and scaled target; depends on srs_pkg.
`timescale 1ns / 1ps

module srs_accum import srs_pkg::*; #(
	parameter int WB   = WEIGHT_BITS_DEF,
	parameter int SUMW = WEIGHT_BITS_DEF + $clog2(MAX_PARTICLES_DEF),
	parameter int SCLW = $clog2(MAX_PARTICLES_DEF + 1) + 1,
	parameter int PW   = SUMW + SCLW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  acc_ctl_t        ctl,
	input  logic [SUMW-1:0] sum,
	input  logic [SCLW-1:0] scale,
	input  logic [WB-1:0]   rdata,
	output logic            gt
);

	logic [PW-1:0] prod_s1;
	logic [PW-1:0] cum_q;
	logic [PW-1:0] tgt_q;
	logic [PW-1:0] add_a;
	logic [PW-1:0] add_b;
	logic [PW-1:0] add_y;
	logic [PW-1:0] sum_x;

	assign sum_x = PW'(sum);

	always_comb begin
		add_a = '0;
		add_b = '0;
		case (ctl.op)
			OP_TGT_INIT: begin
				add_a = sum_x;
				add_b = sum_x << 1;
			end
			OP_TGT_STEP: begin
				add_a = tgt_q;
				add_b = sum_x << 1;
			end
			OP_CUM_ADD: begin
				add_a = cum_q;
				add_b = prod_s1;
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	assign add_y = add_a + add_b;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PW'(scale) * PW'(rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q <= '0;
			tgt_q <= '0;
		end else begin
			if (ctl.clr) begin
				cum_q <= '0;
			end else if (ctl.op == OP_CUM_ADD) begin
				cum_q <= add_y;
			end
			if (ctl.op == OP_TGT_INIT || ctl.op == OP_TGT_STEP) begin
				tgt_q <= add_y;
			end
		end
	end

	assign gt = tgt_q > cum_q;

endmodule

FILE: rtl/systematic_resampler_top.sv
// Systematic resampler top level: load sequencer, draw sequencer, output register.
// Depends on srs_pkg, srs_wmem, srs_accum and systematic_resampler_top_assert.svh.
//
//  port group        dir  handshake              payload
//  ----------------  ---  ---------------------  --------------------------------
//  item / start      in   start & !busy          weight, last_weight
//  draw / strobe     out  strobe (one cycle)     chosen_index, last_draw
//
// Sequencing: a weight that is not marked last is taken and busy stays low.
// The last weight starts drawing: setup (read weight 0, scale it, accumulate),
// then a compare for each draw plus compare, read, multiply and add for every
// pointer advance, with at most N-1 advances. The steps follow the chain
// through the single weight read port, the multiplier and the shared adder.
// Reset: arst_n clears all control state; the weight store is not cleared and is
// only read at entries written in the current set.
// Stalls: the receiver cannot stall; each draw is shown for exactly one cycle.
`timescale 1ns / 1ps

`include "systematic_resampler_top_assert.svh"

module systematic_resampler_top import srs_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  sample_t item,
	output logic    strobe,
	output draw_t   draw
);

	localparam int IB   = $clog2(MAX_PARTICLES);           // pointer / address bits
	localparam int CNTW = $clog2(MAX_PARTICLES + 1);       // count up to MAX_PARTICLES
	localparam int SUMW = WEIGHT_BITS + IB;                // total weight S
	localparam int SCLW = CNTW + 1;                        // scale 2*(N+1)
	localparam int PW   = SUMW + SCLW;                     // scaled values
	localparam int WIN  = (WEIGHT_BITS < WEIGHT_FIELD_W) ? WEIGHT_BITS : WEIGHT_FIELD_W;

	typedef logic [WEIGHT_BITS-1:0] wt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TINIT,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_CMP
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q;      // weights stored in this set
	logic [CNTW-1:0] n_q;        // N for the draws
	logic [CNTW-1:0] k_q;        // draw counter
	logic [IB-1:0]   ptr_q;      // select pointer
	logic [SUMW-1:0] sum_q;      // total weight S
	logic [SCLW-1:0] scale_q;    // 2*(N+1)
	logic            strobe_q;
	draw_t           draw_q;

	logic            accept;
	logic            room;
	wt_t             w_eff;
	logic [CNTW-1:0] n_new;
	logic [IB-1:0]   ptr_nxt;
	logic            can_adv;
	logic            is_last;
	logic [WEIGHT_BITS-1:0] rdata;
	logic            gt;
	acc_ctl_t        ctl;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign room    = (cnt_q < CNTW'(MAX_PARTICLES));
	assign w_eff   = wt_t'(item.weight[WIN-1:0]);
	assign n_new   = room ? (cnt_q + CNTW'(1)) : cnt_q;
	assign ptr_nxt = ptr_q + IB'(1);
	// pointer may move only while the next entry is below N
	assign can_adv = (CNTW'(ptr_q) + CNTW'(1)) < n_q;
	assign is_last = (k_q + CNTW'(1)) == n_q;

	// control to the shared arithmetic unit
	always_comb begin
		ctl.op     = OP_NONE;
		ctl.mul_en = 1'b0;
		ctl.clr    = accept && item.last_weight;
		case (state_q)
			ST_TINIT: ctl.op = OP_TGT_INIT;
			ST_MUL:   ctl.mul_en = 1'b1;
			ST_ACC:   ctl.op = OP_CUM_ADD;
			ST_CMP: begin
				if (!(gt && can_adv) && !is_last) begin
					ctl.op = OP_TGT_STEP;
				end
			end
			default: ctl.op = OP_NONE;
		endcase
	end

	srs_wmem #(
		.DEPTH (MAX_PARTICLES),
		.WB    (WEIGHT_BITS),
		.AW    (IB)
	) u_wmem (
		.clk   (clk),
		.we    (accept && room),
		.waddr (cnt_q[IB-1:0]),
		.wdata (w_eff),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	srs_accum #(
		.WB   (WEIGHT_BITS),
		.SUMW (SUMW),
		.SCLW (SCLW),
		.PW   (PW)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sum    (sum_q),
		.scale  (scale_q),
		.rdata  (rdata),
		.gt     (gt)
	);

	// sequencer: state plus registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			k_q      <= '0;
			ptr_q    <= '0;
			sum_q    <= '0;
			scale_q  <= '0;
			strobe_q <= 1'b0;
			draw_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + CNTW'(1);
							sum_q <= sum_q + SUMW'(w_eff);
						end
						if (item.last_weight) begin
							n_q     <= n_new;
							scale_q <= SCLW'({n_new, 1'b0}) + SCLW'(2);
							k_q     <= '0;
							ptr_q   <= '0;
							state_q <= ST_TINIT;
						end
					end
				end
				// weight 0 is read here while the target is set to 3*S
				ST_TINIT: state_q <= ST_MUL;
				ST_READ:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_CMP;
				ST_CMP: begin
					if (gt && can_adv) begin
						ptr_q   <= ptr_nxt;
						state_q <= ST_READ;
					end else begin
						strobe_q            <= 1'b1;
						draw_q.chosen_index <= INDEX_FIELD_W'(ptr_q);
						draw_q.last_draw    <= is_last;
						if (is_last) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + CNTW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign draw   = draw_q;

	`SRS_ASSERT_IMP(a_ptr_in_set, strobe_q, CNTW'(ptr_q) < n_q, "draw index beyond set size")
	`SRS_ASSERT_NXT(a_last_ends, strobe_q && draw_q.last_draw, !strobe_q, "draw after final draw")
	`SRS_ASSERT_NXT(a_last_starts, accept && item.last_weight, busy, "final weight did not start drawing")
	`SRS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNTW'(MAX_PARTICLES), "weight count above capacity")

endmodule
